// ===== sv/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the simulation time stepper
// Operation codes, status codes and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Width of the time and step fields on the ports
    localparam int FIELD_W = 32;
    // Width of the step counter
    localparam int CNT_W   = 32;
    // Width of the snap tolerance register
    localparam int TOL_W   = 16;
    // Width of the configuration register index
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        FUNC_ADVANCE = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_STEP    = 2'd2,
        FUNC_RESTART = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_ASCEND = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_CNT_OVF    = 3'd3,
        ST_END_BEFORE = 3'd4,
        ST_ZERO_STEP  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME   = 2'd0,
        CFG_END_TIME     = 2'd1,
        CFG_INITIAL_STEP = 2'd2,
        CFG_TOLERANCE    = 2'd3
    } cfg_idx_t;

endpackage

// ===== sv/sts_ram.sv =====
// ----------------------------------------------------------------------------
// sts_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address collision.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sts_next_time.sv =====
// ----------------------------------------------------------------------------
// sts_next_time: next time calculation
// Regular step term with saturation, then snap to the end time and to the
// next unpassed breakpoint.
// ----------------------------------------------------------------------------
module sts_next_time #(
    parameter int TIME_WIDTH = 32,
    parameter int PASS_WIDTH = 5
) (
    input  logic [TIME_WIDTH-1:0]       base_time,
    input  logic [TIME_WIDTH-1:0]       step_size,
    input  logic [sts_pkg::CNT_W-1:0]   step_count,
    input  logic [PASS_WIDTH-1:0]       passed,
    input  logic [TIME_WIDTH-1:0]       bp_time,
    input  logic                        bp_valid,
    input  logic [TIME_WIDTH-1:0]       limit_time,
    input  logic [sts_pkg::TOL_W-1:0]   tolerance,
    output logic [TIME_WIDTH-1:0]       snap_time,
    output logic                        take_bp
);

    import sts_pkg::*;

    localparam int PROD_W = CNT_W + TIME_WIDTH;
    localparam int CMP_W  = (TIME_WIDTH > TOL_W) ? TIME_WIDTH : TOL_W;

    logic [CNT_W-1:0]      k;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W:0]       sum;
    logic                  sat;
    logic [TIME_WIDTH-1:0] reg_time;
    logic [TIME_WIDTH-1:0] end_snap;

    // t at or past target, or short of it by no more than the tolerance
    function automatic logic near(input logic [TIME_WIDTH-1:0] target,
                                  input logic [TIME_WIDTH-1:0] t,
                                  input logic [TOL_W-1:0]      tol);
        logic [TIME_WIDTH-1:0] gap;
        gap = target - t;
        return (t >= target) || (CMP_W'(gap) <= CMP_W'(tol));
    endfunction

    always_comb
    begin
        k    = step_count - CNT_W'(passed) + CNT_W'(1);
        prod = {{TIME_WIDTH{1'b0}}, k} * {{CNT_W{1'b0}}, step_size};
        sum  = {1'b0, prod} + (PROD_W + 1)'(base_time);
        // saturate when the sum leaves the time range
        sat  = |sum[PROD_W:TIME_WIDTH];
        reg_time = sat ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

        end_snap = near(limit_time, reg_time, tolerance) ? limit_time : reg_time;

        take_bp   = bp_valid && near(bp_time, end_snap, tolerance);
        snap_time = take_bp ? bp_time : end_snap;
    end

endmodule

// ===== sv/sim_time_stepper.sv =====
// ----------------------------------------------------------------------------
// sim_time_stepper: integer-tick simulation time stepper
// Advances time in regular steps from a start to an end time and stops at
// breakpoint times loaded in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func and operand. func selects
//   advance, append breakpoint, change step size or restart. Every input
//   transaction yields exactly one result transaction on the output channel
//   (out_valid/out_stall): current time, upcoming time, step length, steps
//   taken, at-end flag and status.
//   The result is written to the output register at the edge that accepts
//   the input. Throughput is one transaction per cycle while the receiver
//   does not stall; the step multiply, the snap compares and the
//   breakpoint lookup all sit in logic between the state and result registers.
//   When the receiver stalls, the result holds in the output register and
//   in_stall rises, so no new transaction is taken until it drains.
//   The breakpoint table is a RAM; the entry at the current breakpoint
//   index is prefetched every cycle so it is ready for the next item.
//   Reset (rst_n low, asynchronous) restores the register defaults, clears
//   time, counters and the breakpoint count. No clearing pass is needed.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once
//   and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module sim_time_stepper #(
    parameter int MAX_BREAKPOINTS = 16,
    parameter int TIME_WIDTH      = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              cfg_we,
    input  logic [sts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sts_pkg::FIELD_W-1:0]       cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [sts_pkg::FIELD_W-1:0]       operand,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sts_pkg::FIELD_W-1:0]       current_time,
    output logic [sts_pkg::FIELD_W-1:0]       upcoming_time,
    output logic [sts_pkg::FIELD_W-1:0]       step_length,
    output logic [sts_pkg::CNT_W-1:0]         steps_taken,
    output logic                              at_end,
    output logic [2:0]                        status
);

    import sts_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int PW = $clog2(MAX_BREAKPOINTS + 1);
    localparam int AW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam logic [PW-1:0] BP_MAX = PW'(MAX_BREAKPOINTS);

    // configuration registers
    logic [TW-1:0]    start_reg;
    logic [TW-1:0]    end_reg;
    logic [TW-1:0]    init_step_reg;
    logic [TOL_W-1:0] tol_reg;

    // stepper state
    logic [TW-1:0]    now_reg,    now_next;
    logic [TW-1:0]    follow_reg, follow_next;
    logic [TW-1:0]    step_reg,   step_next;
    logic [TW-1:0]    base_reg,   base_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PW-1:0]    passed_reg, passed_next;
    logic [PW-1:0]    bpcnt_reg,  bpcnt_next;

    // cached breakpoint entries: first, last appended, last passed
    logic [TW-1:0]    first_reg,  first_next;
    logic [TW-1:0]    tail_reg,   tail_next;
    logic [TW-1:0]    last_reg,   last_next;

    // bypass for an entry written the cycle before it is read
    logic             fwd_reg;
    logic [TW-1:0]    fwd_data_reg;

    // output register
    logic             out_valid_reg;
    logic [FIELD_W-1:0] cur_out_reg;
    logic [FIELD_W-1:0] up_out_reg;
    logic [FIELD_W-1:0] len_out_reg;
    logic [CNT_W-1:0]   cnt_out_reg;
    logic               end_out_reg;
    status_t            status_reg;

    logic             accept;
    func_t            fn;
    logic [TW-1:0]    opnd;
    logic [TW-1:0]    ram_q;
    logic [TW-1:0]    next_bp;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;

    // operands of the next time calculation
    logic [TW-1:0]    base_sel;
    logic [TW-1:0]    step_sel;
    logic [CNT_W-1:0] cnt_sel;
    logic [PW-1:0]    pass_sel;
    logic [TW-1:0]    cand_sel;
    logic             cand_valid;
    logic [TW-1:0]    nt_time;
    logic             nt_take;

    logic             run;
    status_t          status_c;
    logic [TW-1:0]    len_c;

    // accept whenever the output register is free or draining this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign fn       = func_t'(func);
    assign opnd     = TW'(operand);
    assign next_bp  = fwd_reg ? fwd_data_reg : ram_q;

    // breakpoint table
    assign ram_waddr = bpcnt_reg[AW-1:0];
    assign ram_raddr = passed_next[AW-1:0];

    sts_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_BREAKPOINTS)
    ) u_bp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (opnd),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // select the operands of the next time calculation per operation
    always_comb
    begin
        base_sel = base_reg;
        step_sel = step_reg;
        cnt_sel  = count_reg;
        pass_sel = passed_reg;
        cand_sel = next_bp;
        case (fn)
            FUNC_ADVANCE:
            begin
                cnt_sel = count_reg + CNT_W'(1);
            end
            FUNC_STEP:
            begin
                base_sel = now_reg;
                step_sel = opnd;
                cnt_sel  = '0;
            end
            FUNC_RESTART:
            begin
                base_sel = start_reg;
                step_sel = init_step_reg;
                cnt_sel  = '0;
                pass_sel = '0;
                cand_sel = first_reg;
            end
            default:
            begin
            end
        endcase
        cand_valid = pass_sel < bpcnt_reg;
    end

    sts_next_time #(
        .TIME_WIDTH (TW),
        .PASS_WIDTH (PW)
    ) u_next_time (
        .base_time  (base_sel),
        .step_size  (step_sel),
        .step_count (cnt_sel),
        .passed     (pass_sel),
        .bp_time    (cand_sel),
        .bp_valid   (cand_valid),
        .limit_time (end_reg),
        .tolerance  (tol_reg),
        .snap_time  (nt_time),
        .take_bp    (nt_take)
    );

    // state update for the accepted transaction
    always_comb
    begin
        now_next    = now_reg;
        follow_next = follow_reg;
        step_next   = step_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        passed_next = passed_reg;
        bpcnt_next  = bpcnt_reg;
        first_next  = first_reg;
        tail_next   = tail_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        run         = 1'b0;
        status_c    = ST_OK;

        if (accept)
        begin
            case (fn)
                FUNC_ADVANCE:
                begin
                    if (count_reg == {CNT_W{1'b1}})
                    begin
                        status_c = ST_CNT_OVF;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        now_next   = follow_reg;
                        run        = 1'b1;
                    end
                end
                FUNC_APPEND:
                begin
                    if (bpcnt_reg >= BP_MAX)
                    begin
                        status_c = ST_TABLE_FULL;
                    end
                    else if (bpcnt_reg != '0 && opnd <= tail_reg)
                    begin
                        status_c = ST_NOT_ASCEND;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        bpcnt_next = bpcnt_reg + PW'(1);
                        tail_next  = opnd;
                        if (bpcnt_reg == '0)
                        begin
                            first_next = opnd;
                        end
                    end
                end
                FUNC_STEP:
                begin
                    if (opnd == '0)
                    begin
                        status_c = ST_ZERO_STEP;
                    end
                    else if (opnd != step_reg)
                    begin
                        step_next  = opnd;
                        base_next  = now_reg;
                        count_next = '0;
                        run        = 1'b1;
                    end
                end
                FUNC_RESTART:
                begin
                    if (end_reg < start_reg)
                    begin
                        status_c = ST_END_BEFORE;
                    end
                    else if (init_step_reg == '0)
                    begin
                        status_c = ST_ZERO_STEP;
                    end
                    else
                    begin
                        step_next  = init_step_reg;
                        base_next  = start_reg;
                        now_next   = start_reg;
                        count_next = '0;
                        run        = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (run)
        begin
            follow_next = nt_time;
            passed_next = pass_sel + PW'(nt_take);
            if (nt_take)
            begin
                last_next = cand_sel;
            end
        end

        // step length as seen after this transaction
        len_c = step_next;
        if (follow_next == end_reg)
        begin
            len_c = end_reg - now_next;
        end
        if (passed_next != '0 && (follow_next == last_next || now_next == last_next))
        begin
            len_c = follow_next - now_next;
        end
    end

    // configuration, state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            end_reg       <= TW'(1000);
            init_step_reg <= TW'(1);
            tol_reg       <= '0;
            now_reg       <= '0;
            follow_reg    <= '0;
            step_reg      <= TW'(1);
            base_reg      <= '0;
            count_reg     <= '0;
            passed_reg    <= '0;
            bpcnt_reg     <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_START_TIME:   start_reg     <= TW'(cfg_data);
                    CFG_END_TIME:     end_reg       <= TW'(cfg_data);
                    CFG_INITIAL_STEP: init_step_reg <= TW'(cfg_data);
                    CFG_TOLERANCE:    tol_reg       <= cfg_data[TOL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            now_reg    <= now_next;
            follow_reg <= follow_next;
            step_reg   <= step_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
            passed_reg <= passed_next;
            bpcnt_reg  <= bpcnt_next;
            // the RAM returns old data on a collision: take the written value
            fwd_reg    <= ram_we && (ram_waddr == ram_raddr);
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // cached entries and result payload
    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        tail_reg     <= tail_next;
        last_reg     <= last_next;
        fwd_data_reg <= opnd;
        if (accept)
        begin
            cur_out_reg <= FIELD_W'(now_next);
            up_out_reg  <= FIELD_W'(follow_next);
            len_out_reg <= FIELD_W'(len_c);
            cnt_out_reg <= count_next;
            end_out_reg <= now_next >= end_reg;
            status_reg  <= status_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_time  = cur_out_reg;
    assign upcoming_time = up_out_reg;
    assign step_length   = len_out_reg;
    assign steps_taken   = cnt_out_reg;
    assign at_end        = end_out_reg;
    assign status        = status_reg;

endmodule

// ===== tb/tb_sim_time_stepper.sv =====
// ----------------------------------------------------------------------------
// tb_sim_time_stepper: self-checking testbench of the simulation time stepper
// Walks a directed table, then phases of random operations. Every input
// transaction is run through a local model of the stepper. Each result
// transaction is compared field by field with the oldest predicted view.
// The directed part covers the reset state, the register extremes and
// most error codes. The random phases reconfigure the block and vary the pacing:
// no idling, sender gaps, receiver stalls, and both together.
// ----------------------------------------------------------------------------
module tb_sim_time_stepper;

    import sts_pkg::*;

    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 63;
    localparam int          NUM_BPS         = 16;
    localparam logic [31:0] TIME_MAX        = 32'hFFFF_FFFF;

    // Pacing of the two channels during a phase
    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    // What one result transaction carries
    typedef struct packed {
        logic [31:0] current;
        logic [31:0] upcoming;
        logic [31:0] length;
        logic [31:0] count;
        logic        done;
        status_t     code;
    } stepper_view_t;

    // Directed table: a register write, an operation checked by the model,
    // or an operation with its result typed in
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_OP,
        ROW_CHK
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [1:0]    code;
        logic [31:0]   value;
        stepper_view_t view;
    } plan_row_t;

    localparam stepper_view_t NO_VIEW = '0;

    localparam int PLAN_ROWS = 33;
    localparam plan_row_t DIRECTED [PLAN_ROWS] = '{
        '{ROW_CFG, CFG_START_TIME,   32'd0,   NO_VIEW},
        '{ROW_CFG, CFG_END_TIME,     32'd100, NO_VIEW},
        '{ROW_CFG, CFG_INITIAL_STEP, 32'd10,  NO_VIEW},
        '{ROW_CFG, CFG_TOLERANCE,    32'd3,   NO_VIEW},
        // advance straight out of reset, before any restart
        '{ROW_CHK, FUNC_ADVANCE, TIME_MAX,
          '{32'd0, 32'd2, 32'd1, 32'd1, 1'b0, ST_OK}},
        '{ROW_CHK, FUNC_RESTART, 32'd0,
          '{32'd0, 32'd10, 32'd10, 32'd0, 1'b0, ST_OK}},
        '{ROW_OP,  FUNC_APPEND,  32'd25, NO_VIEW},
        // equal breakpoint is not ascending
        '{ROW_CHK, FUNC_APPEND,  32'd25,
          '{32'd0, 32'd10, 32'd10, 32'd0, 1'b0, ST_NOT_ASCEND}},
        '{ROW_OP,  FUNC_APPEND,  32'd50, NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE, 32'd0,  NO_VIEW},
        // overshoots the first breakpoint and snaps back to it
        '{ROW_OP,  FUNC_ADVANCE, 32'd0,  NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE, 32'd0,  NO_VIEW},
        '{ROW_CHK, FUNC_STEP,    32'd0,
          '{32'd25, 32'd30, 32'd5, 32'd3, 1'b0, ST_ZERO_STEP}},
        // same step size: nothing moves
        '{ROW_OP,  FUNC_STEP,    32'd10,   NO_VIEW},
        // widest step: later advances saturate, snapping to 50 and then to 100
        '{ROW_OP,  FUNC_STEP,    TIME_MAX, NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE, 32'd0,    NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE, 32'd0,    NO_VIEW},
        '{ROW_OP,  FUNC_STEP,    32'd7,    NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE, 32'd0,    NO_VIEW},
        '{ROW_OP,  FUNC_APPEND,  32'd0,    NO_VIEW},
        // end before start
        '{ROW_CFG, CFG_START_TIME, 32'd200, NO_VIEW},
        '{ROW_OP,  FUNC_RESTART,   32'd0,   NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE,   32'd0,   NO_VIEW},
        // zero initial step
        '{ROW_CFG, CFG_START_TIME,   32'd0, NO_VIEW},
        '{ROW_CFG, CFG_INITIAL_STEP, 32'd0, NO_VIEW},
        '{ROW_OP,  FUNC_RESTART,     32'd0, NO_VIEW},
        // initial step, end and tolerance at their top values
        '{ROW_CFG, CFG_INITIAL_STEP, TIME_MAX,      NO_VIEW},
        '{ROW_CFG, CFG_END_TIME,     TIME_MAX,      NO_VIEW},
        '{ROW_CFG, CFG_TOLERANCE,    32'h0000_FFFF, NO_VIEW},
        '{ROW_OP,  FUNC_RESTART,     32'd0,         NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE,     32'd0,         NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE,     32'd0,         NO_VIEW},
        '{ROW_OP,  FUNC_ADVANCE,     32'd0,         NO_VIEW}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] operand;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] current_time;
    logic [31:0] upcoming_time;
    logic [31:0] step_length;
    logic [31:0] steps_taken;
    logic        at_end;
    logic [2:0]  status;

    // Views predicted for accepted transactions, oldest first
    stepper_view_t pending_views [$];
    pace_t         pace = PACE_FULL;
    int            failures = 0;
    int            cycle_count = 0;

    // Local copy of the registers, at their reset values
    logic [31:0] r_start     = 32'd0;
    logic [31:0] r_end       = 32'd1000;
    logic [31:0] r_init_step = 32'd1;
    logic [15:0] r_tol       = 16'd0;

    // Local copy of the stepper state, at its reset values
    logic [31:0] tm_now   = 32'd0;
    logic [31:0] tm_next  = 32'd0;
    logic [31:0] tm_step  = 32'd1;
    logic [31:0] tm_base  = 32'd0;
    logic [31:0] tm_count = 32'd0;
    int          bp_hits   = 0;
    int          bp_loaded = 0;
    logic [31:0] bp_times [NUM_BPS];

    sim_time_stepper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .operand       (operand),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_time  (current_time),
        .upcoming_time (upcoming_time),
        .step_length   (step_length),
        .steps_taken   (steps_taken),
        .at_end        (at_end),
        .status        (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Time model
    // ------------------------------------------------------------------------

    // A time counts as reached when it is past the target or within tolerance
    function automatic bit close_to(logic [31:0] target, logic [31:0] t);
        return (t >= target) || ((target - t) <= {16'd0, r_tol});
    endfunction

    // Next regular time, snapped to the end and then to the next breakpoint;
    // a breakpoint snapped to counts as passed
    function automatic logic [31:0] plan_next_time();
        logic [31:0] k;
        logic [63:0] reach;
        logic [31:0] nxt;
        k = tm_count - 32'(bp_hits) + 32'd1;
        if (k != 32'd0 && tm_step > (TIME_MAX - tm_base) / k)
            nxt = TIME_MAX;
        else
        begin
            reach = 64'(tm_base) + 64'(k) * 64'(tm_step);
            nxt   = reach[31:0];
        end
        if (close_to(r_end, nxt))
            nxt = r_end;
        if (bp_hits < bp_loaded && close_to(bp_times[bp_hits], nxt))
        begin
            nxt = bp_times[bp_hits];
            bp_hits++;
        end
        return nxt;
    endfunction

    // Length of the coming step, shortened at the end or around a breakpoint
    function automatic logic [31:0] live_step_length();
        logic [31:0] dt;
        dt = tm_step;
        if (tm_next == r_end)
            dt = r_end - tm_now;
        if (bp_hits > 0 &&
            (tm_next == bp_times[bp_hits-1] || tm_now == bp_times[bp_hits-1]))
            dt = tm_next - tm_now;
        return dt;
    endfunction

    // Apply one operation to the model and return the view that results
    function automatic stepper_view_t apply_time_op(func_t f, logic [31:0] op);
        status_t       st;
        stepper_view_t v;
        st = ST_OK;
        case (f)
            FUNC_ADVANCE:
                // the overflow code comes only after 2^32 - 1 advances, out of reach here
                if (tm_count == TIME_MAX)
                    st = ST_CNT_OVF;
                else
                begin
                    tm_count++;
                    tm_now  = tm_next;
                    tm_next = plan_next_time();
                end
            FUNC_APPEND:
                if (bp_loaded >= NUM_BPS)
                    st = ST_TABLE_FULL;
                else if (bp_loaded > 0 && op <= bp_times[bp_loaded-1])
                    st = ST_NOT_ASCEND;
                else
                begin
                    bp_times[bp_loaded] = op;
                    bp_loaded++;
                end
            FUNC_STEP:
                if (op == 32'd0)
                    st = ST_ZERO_STEP;
                else if (op != tm_step)
                begin
                    // rebase at the current time; passed breakpoints stay passed
                    tm_step  = op;
                    tm_base  = tm_now;
                    tm_count = 32'd0;
                    tm_next  = plan_next_time();
                end
            default:
                if (r_end < r_start)
                    st = ST_END_BEFORE;
                else if (r_init_step == 32'd0)
                    st = ST_ZERO_STEP;
                else
                begin
                    tm_step  = r_init_step;
                    tm_base  = r_start;
                    tm_now   = r_start;
                    tm_count = 32'd0;
                    bp_hits  = 0;
                    tm_next  = plan_next_time();
                end
        endcase
        v.current  = tm_now;
        v.upcoming = tm_next;
        v.length   = live_step_length();
        v.count    = tm_count;
        v.done     = (tm_now >= r_end);
        v.code     = st;
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Roll whether a channel idles this cycle under the current pacing
    function automatic bit roll_idle(bit sender);
        int pct;
        case (pace)
            PACE_SENDER_GAPS:     pct = sender ? 57 : 0;
            PACE_RECEIVER_STALLS: pct = sender ? 0 : 57;
            PACE_BOTH:            pct = 18;
            default:              pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // Write one register once every predicted result has drained
    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_TIME:   r_start     = data;
            CFG_END_TIME:     r_end       = data;
            CFG_INITIAL_STEP: r_init_step = data;
            default:          r_tol       = data[15:0];
        endcase
        @(posedge clk);
    endtask

    // Send one operation; on acceptance, queue the view it must produce.
    // Valid stays high on return so back-to-back transactions need no gap.
    task automatic drive_item(func_t f, logic [31:0] op, bit typed,
                              stepper_view_t typed_view);
        stepper_view_t v;
        while (roll_idle(1'b1))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        operand  <= op;
        // hold the payload until the block takes it
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        v = apply_time_op(f, op);
        pending_views.insert(pending_views.size(), typed ? typed_view : v);
    endtask

    // Receiver: stall at random under the current pacing
    always @(posedge clk)
        out_stall <= roll_idle(1'b0);

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : take_result
        stepper_view_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_views.size() == 0)
            begin
                $display("%0t: result transaction with none predicted, current_time %0h",
                         $time, current_time);
                failures++;
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("current_time",  want.current,  current_time);
                check_field("upcoming_time", want.upcoming, upcoming_time);
                check_field("step_length",   want.length,   step_length);
                check_field("steps_taken",   want.count,    steps_taken);
                check_field("at_end",        {31'd0, want.done}, {31'd0, at_end});
                check_field("status",        {29'd0, want.code}, {29'd0, status});
            end
        end
    end

    // Give up on a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending",
                     $time, pending_views.size());
            $display("tb_sim_time_stepper: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        logic [31:0] op;
        logic [31:0] last_bp;
        logic [31:0] first;
        func_t       f;
        int          roll;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_START_TIME;
        cfg_data  <= 32'd0;
        in_valid  <= 1'b0;
        func      <= FUNC_ADVANCE;
        operand   <= 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            case (DIRECTED[r].kind)
                ROW_CFG: write_reg(cfg_idx_t'(DIRECTED[r].code), DIRECTED[r].value);
                ROW_CHK: drive_item(func_t'(DIRECTED[r].code), DIRECTED[r].value,
                                    1'b1, DIRECTED[r].view);
                default: drive_item(func_t'(DIRECTED[r].code), DIRECTED[r].value,
                                    1'b0, NO_VIEW);
            endcase
        end

        // Random phases: reconfigure while idle, then restart and run
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // full time range, huge step, widest tolerance
                    write_reg(CFG_START_TIME,   32'd0);
                    write_reg(CFG_END_TIME,     TIME_MAX);
                    write_reg(CFG_INITIAL_STEP, 32'h3000_0000);
                    write_reg(CFG_TOLERANCE,    32'h0000_FFFF);
                end
                1:
                begin
                    // start pinned at the top of the range
                    write_reg(CFG_START_TIME,   TIME_MAX);
                    write_reg(CFG_END_TIME,     TIME_MAX);
                    write_reg(CFG_INITIAL_STEP, 32'd1);
                    write_reg(CFG_TOLERANCE,    32'd0);
                end
                2:
                begin
                    // every restart refused: end before start
                    write_reg(CFG_START_TIME,   32'd5000);
                    write_reg(CFG_END_TIME,     32'd4000);
                    write_reg(CFG_INITIAL_STEP, 32'd5);
                    write_reg(CFG_TOLERANCE,    32'd2);
                end
                3:
                begin
                    // every restart refused: zero initial step
                    write_reg(CFG_START_TIME,   32'd100);
                    write_reg(CFG_END_TIME,     32'd2100);
                    write_reg(CFG_INITIAL_STEP, 32'd0);
                    write_reg(CFG_TOLERANCE,    32'd1);
                end
                default:
                begin
                    // a window that overlaps the loaded breakpoints
                    first = $urandom_range(0, 2000);
                    write_reg(CFG_START_TIME,   first);
                    write_reg(CFG_END_TIME,     first + $urandom_range(100, 3000));
                    write_reg(CFG_INITIAL_STEP, $urandom_range(1, 40));
                    write_reg(CFG_TOLERANCE,    $urandom_range(0, 6));
                end
            endcase
            pace = pace_t'(p % 4);

            drive_item(FUNC_RESTART, $urandom, 1'b0, NO_VIEW);
            for (int i = 1; i < ITEMS_PER_PHASE; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    f  = FUNC_RESTART;
                    op = $urandom;
                end
                else if (roll < 11)
                begin
                    // mostly ascending breakpoints near the active window;
                    // the last free slot takes the top time value
                    f       = FUNC_APPEND;
                    last_bp = (bp_loaded > 0) ? bp_times[bp_loaded-1] : 32'd0;
                    if ($urandom_range(0, 3) == 0)
                        op = $urandom_range(0, last_bp);
                    else if (bp_loaded == NUM_BPS - 1)
                        op = TIME_MAX;
                    else
                        op = last_bp + $urandom_range(1, 400);
                end
                else if (roll < 17)
                begin
                    f = FUNC_STEP;
                    case ($urandom_range(0, 7))
                        0:       op = 32'd0;
                        1:       op = tm_step;
                        2:       op = $urandom;
                        default: op = $urandom_range(1, 64);
                    endcase
                end
                else
                begin
                    f  = FUNC_ADVANCE;
                    op = $urandom;
                end
                drive_item(f, op, 1'b0, NO_VIEW);
            end
        end

        // Drain, then let the output register settle
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (failures == 0)
            $display("tb_sim_time_stepper: PASS");
        else
            $display("tb_sim_time_stepper: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sts_pkg.sv
sv/sts_ram.sv
sv/sts_next_time.sv
sv/sim_time_stepper.sv
tb/tb_sim_time_stepper.sv
